@@ sv/arxms_pkg.sv @@
package arxms_pkg;

    // fixed register formats
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 14;
    localparam int TD_W      = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // coefficients that exist as registers
    localparam int NUM_COEF_A = 3;
    localparam int NUM_COEF_B = 3;

    localparam logic [TD_W-1:0] TD_RESET = TD_W'(1);

    // defaults for the top-level parameters
    localparam int DEF_NUM_A        = 3;
    localparam int DEF_NUM_B        = 3;
    localparam int DEF_MAX_DELAY    = 8;
    localparam int DEF_SAMPLE_WIDTH = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_A1         = 3'd0,
        REG_COEF_A2         = 3'd1,
        REG_COEF_A3         = 3'd2,
        REG_COEF_B0         = 3'd3,
        REG_COEF_B1         = 3'd4,
        REG_COEF_B2         = 3'd5,
        REG_TRANSPORT_DELAY = 3'd6
    } cfg_reg_t;

endpackage

@@ sv/arxms_history.sv @@
module arxms_history #(
    parameter int NUM_A        = arxms_pkg::DEF_NUM_A,
    parameter int NUM_B        = arxms_pkg::DEF_NUM_B,
    parameter int MAX_DELAY    = arxms_pkg::DEF_MAX_DELAY,
    parameter int SAMPLE_WIDTH = arxms_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 shift_en,
    input  logic        [arxms_pkg::TD_W-1:0]     transport_delay,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample_out,
    output logic signed [SAMPLE_WIDTH-1:0]       u_tap [NUM_B],
    output logic signed [SAMPLE_WIDTH-1:0]       y_tap [NUM_A]
);

    localparam int IN_DEPTH = MAX_DELAY + NUM_B - 1;
    localparam int KW       = $clog2(MAX_DELAY + 1);
    localparam int IW       = $clog2(IN_DEPTH) + 1;

    logic signed [SAMPLE_WIDTH-1:0] u_hist_reg [IN_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] y_hist_reg [NUM_A];
    logic        [KW-1:0]           k_eff;
    logic        [IW-1:0]           tap_base;

    // clamp the delay into 1..MAX_DELAY
    always_comb begin
        if (transport_delay == '0) begin
            k_eff = KW'(1);
        end else if (32'(transport_delay) > 32'(MAX_DELAY)) begin
            k_eff = KW'(MAX_DELAY);
        end else begin
            k_eff = KW'(transport_delay);
        end
        tap_base = IW'(k_eff) - IW'(1);
    end

    // pick tap k-1+j from the input line for each b weight
    always_comb begin
        for (int j = 0; j < NUM_B; j++) begin
            u_tap[j] = '0;
            for (int n = 0; n < IN_DEPTH; n++) begin
                if (IW'(n) == tap_base + IW'(j)) begin
                    u_tap[j] = u_hist_reg[n];
                end
            end
        end
        for (int j = 0; j < NUM_A; j++) begin
            y_tap[j] = y_hist_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < IN_DEPTH; n++) begin
                u_hist_reg[n] <= '0;
            end
            for (int n = 0; n < NUM_A; n++) begin
                y_hist_reg[n] <= '0;
            end
        end else if (shift_en) begin
            u_hist_reg[0] <= sample_in;
            for (int n = 1; n < IN_DEPTH; n++) begin
                u_hist_reg[n] <= u_hist_reg[n-1];
            end
            y_hist_reg[0] <= sample_out;
            for (int n = 1; n < NUM_A; n++) begin
                y_hist_reg[n] <= y_hist_reg[n-1];
            end
        end
    end

endmodule

@@ sv/arxms_mac.sv @@
module arxms_mac #(
    parameter int NUM_A        = arxms_pkg::DEF_NUM_A,
    parameter int NUM_B        = arxms_pkg::DEF_NUM_B,
    parameter int SAMPLE_WIDTH = arxms_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic signed [SAMPLE_WIDTH-1:0]         u_tap  [NUM_B],
    input  logic signed [SAMPLE_WIDTH-1:0]         y_tap  [NUM_A],
    input  logic signed [arxms_pkg::COEF_W-1:0]    coef_b [NUM_B],
    input  logic signed [arxms_pkg::COEF_W-1:0]    coef_a [NUM_A],
    output logic signed [SAMPLE_WIDTH-1:0]         y_out
);

    localparam int PROD_W = SAMPLE_WIDTH + arxms_pkg::COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(NUM_A + NUM_B) + 1;
    localparam logic signed [ACC_W-1:0] SMAX =
        (ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] HALF =
        ACC_W'(1) <<< (arxms_pkg::COEF_FRAC - 1);

    logic signed [PROD_W-1:0] prod_b [NUM_B];
    logic signed [PROD_W-1:0] prod_a [NUM_A];
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  rounded;

    always_comb begin
        for (int j = 0; j < NUM_B; j++) begin
            prod_b[j] = PROD_W'(u_tap[j] * coef_b[j]);
        end
        for (int j = 0; j < NUM_A; j++) begin
            prod_a[j] = PROD_W'(y_tap[j] * coef_a[j]);
        end
    end

    always_comb begin
        acc = '0;
        for (int j = 0; j < NUM_B; j++) begin
            acc = acc + ACC_W'(prod_b[j]);
        end
        for (int j = 0; j < NUM_A; j++) begin
            acc = acc - ACC_W'(prod_a[j]);
        end
        // round half up, then floor shift out the fraction
        rounded = (acc + HALF) >>> arxms_pkg::COEF_FRAC;
        if (rounded > SMAX) begin
            y_out = SAMPLE_WIDTH'(SMAX);
        end else if (rounded < SMIN) begin
            y_out = SAMPLE_WIDTH'(SMIN);
        end else begin
            y_out = SAMPLE_WIDTH'(rounded);
        end
    end

endmodule

@@ sv/arxms_outbuf.sv @@
module arxms_outbuf #(
    parameter int SAMPLE_WIDTH = arxms_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  logic [SAMPLE_WIDTH-1:0] push_data,
    output logic                    full,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [SAMPLE_WIDTH-1:0] m_data
);

    logic [1:0]              count_reg;
    logic [1:0]              count_next;
    logic [SAMPLE_WIDTH-1:0] head_reg;
    logic [SAMPLE_WIDTH-1:0] tail_reg;
    logic                    pop;

    assign m_valid = (count_reg != 2'd0);
    assign full    = (count_reg == 2'd2);
    assign m_data  = head_reg;
    assign pop     = m_valid && m_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // word storage: head is presented, tail holds the second word
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (push) begin
                head_reg <= push_data;
            end else begin
                head_reg <= tail_reg;
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                head_reg <= push_data;
            end else begin
                tail_reg <= push_data;
            end
        end
    end

endmodule

@@ sv/arx_model_step.sv @@
// ARX plant step: one output word per input word.
// Results are registered in the output buffer as each input word is accepted.
// Throughput: one word per cycle while the buffer has room; the output-history
// feedback loop (six multiply-adds, rounding, saturation) is combinational.
// A two-word output buffer keeps input flowing while one result waits.
// Reset (aresetn low, synchronous): histories and coefficients clear, delay = 1.
module arx_model_step #(
    parameter int NUM_A        = arxms_pkg::DEF_NUM_A,
    parameter int NUM_B        = arxms_pkg::DEF_NUM_B,
    parameter int MAX_DELAY    = arxms_pkg::DEF_MAX_DELAY,
    parameter int SAMPLE_WIDTH = arxms_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_sample_in,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       m_sample_out,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [arxms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [arxms_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = arxms_pkg::COEF_W;

    logic signed [CW-1:0]              coef_a_reg [arxms_pkg::NUM_COEF_A];
    logic signed [CW-1:0]              coef_b_reg [arxms_pkg::NUM_COEF_B];
    logic        [arxms_pkg::TD_W-1:0] delay_reg;

    logic signed [CW-1:0]              coef_a [NUM_A];
    logic signed [CW-1:0]              coef_b [NUM_B];
    logic signed [SAMPLE_WIDTH-1:0]    u_tap  [NUM_B];
    logic signed [SAMPLE_WIDTH-1:0]    y_tap  [NUM_A];
    logic signed [SAMPLE_WIDTH-1:0]    y_new;
    logic                              accept;
    logic                              buf_full;
    logic        [SAMPLE_WIDTH-1:0]    buf_data;

    assign cfg_ready    = 1'b1;
    assign s_ready      = !buf_full;
    assign accept       = s_valid && s_ready;
    assign m_sample_out = $signed(buf_data);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < arxms_pkg::NUM_COEF_A; j++) begin
                coef_a_reg[j] <= '0;
            end
            for (int j = 0; j < arxms_pkg::NUM_COEF_B; j++) begin
                coef_b_reg[j] <= '0;
            end
            delay_reg <= arxms_pkg::TD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                arxms_pkg::REG_COEF_A1: coef_a_reg[0] <= $signed(cfg_data[CW-1:0]);
                arxms_pkg::REG_COEF_A2: coef_a_reg[1] <= $signed(cfg_data[CW-1:0]);
                arxms_pkg::REG_COEF_A3: coef_a_reg[2] <= $signed(cfg_data[CW-1:0]);
                arxms_pkg::REG_COEF_B0: coef_b_reg[0] <= $signed(cfg_data[CW-1:0]);
                arxms_pkg::REG_COEF_B1: coef_b_reg[1] <= $signed(cfg_data[CW-1:0]);
                arxms_pkg::REG_COEF_B2: coef_b_reg[2] <= $signed(cfg_data[CW-1:0]);
                arxms_pkg::REG_TRANSPORT_DELAY: begin
                    delay_reg <= cfg_data[arxms_pkg::TD_W-1:0];
                end
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    // taps beyond the register set carry zero weight
    for (genvar j = 0; j < NUM_A; j++) begin : g_coef_a
        if (j < arxms_pkg::NUM_COEF_A) begin : g_reg
            assign coef_a[j] = coef_a_reg[j];
        end else begin : g_zero
            assign coef_a[j] = '0;
        end
    end

    for (genvar j = 0; j < NUM_B; j++) begin : g_coef_b
        if (j < arxms_pkg::NUM_COEF_B) begin : g_reg
            assign coef_b[j] = coef_b_reg[j];
        end else begin : g_zero
            assign coef_b[j] = '0;
        end
    end

    arxms_history #(
        .NUM_A        (NUM_A),
        .NUM_B        (NUM_B),
        .MAX_DELAY    (MAX_DELAY),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_history (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .shift_en        (accept),
        .transport_delay (delay_reg),
        .sample_in       (s_sample_in),
        .sample_out      (y_new),
        .u_tap           (u_tap),
        .y_tap           (y_tap)
    );

    arxms_mac #(
        .NUM_A        (NUM_A),
        .NUM_B        (NUM_B),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .u_tap  (u_tap),
        .y_tap  (y_tap),
        .coef_b (coef_b),
        .coef_a (coef_a),
        .y_out  (y_new)
    );

    arxms_outbuf #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (y_new),
        .full      (buf_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (buf_data)
    );

endmodule
